FILE: src/triggered_breakpoint_envelope_assert.svh
// Assertion macros for the breakpoint envelope generator.
`ifndef TRIGGERED_BREAKPOINT_ENVELOPE_ASSERT_SVH
`define TRIGGERED_BREAKPOINT_ENVELOPE_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define TBE_ASSERT_HOLDS(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("envelope check failed");

// Next-cycle implication, checked on clk outside reset.
`define TBE_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("envelope check failed");

`endif

FILE: src/tbe_pkg.sv
// Shared constants and field layout for the breakpoint envelope generator.
`default_nettype none

package tbe_pkg;

  localparam int POINT_LEVEL_W = 24;
  localparam int POINT_DUR_W   = 24;
  localparam int STEP_W        = 13;
  localparam int SEG_W         = 4;
  localparam int PROD_W        = POINT_LEVEL_W + STEP_W;

  localparam int TRIG_BIT = 0;
  localparam int IDX_LSB  = TRIG_BIT + 1;
  localparam int LVL_LSB  = IDX_LSB + SEG_W;
  localparam int DUR_LSB  = LVL_LSB + POINT_LEVEL_W;
  localparam int S_USED_W = DUR_LSB + POINT_DUR_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  localparam int M_USED_W  = POINT_LEVEL_W + 1 + SEG_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = STEP_W;

  localparam logic [0:0] CMD_TICK = 1'b0;
  localparam logic [0:0] CMD_LOAD = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_TOTAL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE     = 1'b1;

  localparam logic signed [32:0] OUT_MAX_W = 33'sd8388607;
  localparam logic signed [32:0] OUT_MIN_W = -33'sd8388608;
  localparam logic [POINT_LEVEL_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [POINT_LEVEL_W-1:0] OUT_MIN = 24'h800000;

endpackage

`default_nettype wire

FILE: src/triggered_breakpoint_envelope.sv
// Breakpoint envelope generator: breakpoint table, sequencer and bit-serial slope divider.
// One item at a time (s_tready only in ST_IDLE); a load item writes the tables, then goes to ST_FINISH.
// Tick item without a new slope: ST_FETCH0, ST_FETCH1, then ST_ACCUM, ST_LAST or neither, then ST_FINISH.
// Tick item with a new slope: ST_FETCH0, ST_FETCH1, ST_SL_A to ST_SL_C, ST_MUL, the 1-bit-per-cycle divider in ST_DIV,
//   ST_SL_DONE, ST_ACCUM if the slope is applied at once, then ST_FINISH, which waits for a free output.
// Reset (rst, synchronous): state, level, slope and counters clear, segment_total = 1,
//   step_size = 1; breakpoint tables hold no defined value until written.
`default_nettype none
`include "triggered_breakpoint_envelope_assert.svh"

module triggered_breakpoint_envelope #(
  parameter int MAX_SEGMENTS  = 15,
  parameter int LEVEL_BITS    = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // trigger, point_index, point_level, point_duration, zero pad
  input  logic [tbe_pkg::S_TDATA_W-1:0]       s_tdata,
  // command
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // level, playing, segment_now, zero pad
  output logic [tbe_pkg::M_TDATA_W-1:0]       m_tdata,
  input  logic                                cfg_write,
  input  logic [tbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tbe_pkg::*;

  localparam int ACC_W  = LEVEL_BITS + FRACTION_BITS;
  localparam int NUM_W  = PROD_W + FRACTION_BITS;
  localparam int HI_W   = NUM_W - ACC_W + 1;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int ADDR_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [32:0] LVL_MAX_W = (33'sd1 <<< (LEVEL_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] LVL_MIN_W = -(33'sd1 <<< (LEVEL_BITS - 1));

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_FETCH0  = 12'b000000000010,
    ST_FETCH1  = 12'b000000000100,
    ST_LAST    = 12'b000000001000,
    ST_SL_A    = 12'b000000010000,
    ST_SL_B    = 12'b000000100000,
    ST_SL_C    = 12'b000001000000,
    ST_MUL     = 12'b000010000000,
    ST_DIV     = 12'b000100000000,
    ST_SL_DONE = 12'b001000000000,
    ST_ACCUM   = 12'b010000000000,
    ST_FINISH  = 12'b100000000000
  } state_t;

  function automatic logic signed [ACC_W-1:0] level_to_acc(
    input logic signed [POINT_LEVEL_W-1:0] v
  );
    logic signed [32:0] w;
    w = 33'(v);
    if (w > LVL_MAX_W) return ACC_MAX;
    else if (w < LVL_MIN_W) return ACC_MIN;
    else return {w[LEVEL_BITS-1:0], {FRACTION_BITS{1'b0}}};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    else return s[ACC_W-1:0];
  endfunction

  state_t state;

  logic [SEG_W-1:0]  segment_total;
  logic [STEP_W-1:0] step_size;

  logic signed [ACC_W-1:0] level_acc;
  logic signed [ACC_W-1:0] slope;
  logic                    run_flag;
  logic [SEG_W-1:0]        segment_pointer;
  logic [POINT_DUR_W-1:0]  sample_count;

  logic signed [POINT_LEVEL_W-1:0] level_mem [MAX_SEGMENTS+1];
  logic [POINT_DUR_W-1:0]          dur_mem [MAX_SEGMENTS];
  logic [ADDR_W-1:0]               lvl_addr;
  logic [ADDR_W-1:0]               dur_addr;
  logic signed [POINT_LEVEL_W-1:0] lvl_q;
  logic [POINT_DUR_W-1:0]          dur_q;

  logic                            trig;
  logic                            acc_after;
  logic [ADDR_W-1:0]               slope_idx;
  logic signed [POINT_LEVEL_W-1:0] level_a;
  logic [POINT_DUR_W-1:0]          div_d;
  logic                            div_neg;
  logic [POINT_LEVEL_W-1:0]        mag;
  logic [NUM_W-1:0]                num_sr;
  logic [NUM_W-1:0]                quo;
  logic [POINT_DUR_W-1:0]          rem;
  logic [CNT_W-1:0]                div_cnt;

  logic [SEG_W-1:0]         total;
  logic [SEG_W-1:0]         seg_inc;
  logic                     in_range;
  logic                     accepted;
  logic                     out_free;
  logic [POINT_LEVEL_W:0]   diff;
  logic [POINT_LEVEL_W:0]   diff_abs;
  logic [POINT_DUR_W:0]     trial;
  logic                     qbit;
  logic [HI_W-1:0]          q_hi;
  logic [ACC_W-2:0]         q_lo;
  logic [ACC_W-1:0]         q_mag;
  logic [POINT_DUR_W:0]     cnt_sum;
  logic signed [32:0]       lev_w;
  logic [POINT_LEVEL_W-1:0] level_out;

  assign s_tready = (state == ST_IDLE);
  assign accepted = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign seg_inc  = segment_pointer + SEG_W'(1);

  always_comb begin
    if (32'(segment_total) > MAX_SEGMENTS) total = SEG_W'(MAX_SEGMENTS);
    else total = segment_total;
  end

  assign in_range = (run_flag || trig) && (segment_pointer < total);

  assign diff     = {lvl_q[POINT_LEVEL_W-1], lvl_q} - {level_a[POINT_LEVEL_W-1], level_a};
  assign diff_abs = diff[POINT_LEVEL_W] ? ((POINT_LEVEL_W+1)'(0) - diff) : diff;

  assign trial = {rem, num_sr[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, div_d});

  assign q_hi  = quo[NUM_W-1:ACC_W-1];
  assign q_lo  = quo[ACC_W-2:0];
  assign q_mag = quo[ACC_W-1:0];

  assign cnt_sum = {1'b0, sample_count} + (POINT_DUR_W+1)'(step_size);

  always_comb begin
    lev_w = 33'($signed(level_acc[ACC_W-1:FRACTION_BITS]));
    if (lev_w > OUT_MAX_W) level_out = OUT_MAX;
    else if (lev_w < OUT_MIN_W) level_out = OUT_MIN;
    else level_out = lev_w[POINT_LEVEL_W-1:0];
  end

  always_comb begin
    unique case (state)
      ST_FETCH1: lvl_addr = ADDR_W'(total);
      ST_SL_A:   lvl_addr = slope_idx;
      ST_SL_B:   lvl_addr = slope_idx + ADDR_W'(1);
      default:   lvl_addr = '0;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_FETCH0: dur_addr = ADDR_W'(segment_pointer);
      ST_SL_A:   dur_addr = slope_idx;
      default:   dur_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accepted && s_tuser == CMD_LOAD) begin
      if (32'(s_tdata[IDX_LSB +: SEG_W]) <= MAX_SEGMENTS) begin
        level_mem[ADDR_W'(s_tdata[IDX_LSB +: SEG_W])] <= s_tdata[LVL_LSB +: POINT_LEVEL_W];
      end
      if (32'(s_tdata[IDX_LSB +: SEG_W]) < MAX_SEGMENTS) begin
        dur_mem[ADDR_W'(s_tdata[IDX_LSB +: SEG_W])] <= s_tdata[DUR_LSB +: POINT_DUR_W];
      end
    end
    lvl_q <= level_mem[lvl_addr];
    dur_q <= dur_mem[dur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_total <= SEG_W'(1);
      step_size     <= STEP_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEGMENT_TOTAL: segment_total <= cfg_data[SEG_W-1:0];
        REG_STEP_SIZE:     step_size     <= cfg_data[STEP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      level_acc       <= '0;
      slope           <= '0;
      run_flag        <= 1'b0;
      segment_pointer <= '0;
      sample_count    <= '0;
      trig            <= 1'b0;
      acc_after       <= 1'b0;
      div_cnt         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accepted) begin
            trig  <= s_tdata[TRIG_BIT];
            state <= (s_tuser == CMD_LOAD) ? ST_FINISH : ST_FETCH0;
          end
        end
        ST_FETCH0: state <= ST_FETCH1;
        ST_FETCH1: begin
          if (trig) begin
            level_acc <= level_to_acc(lvl_q);
            run_flag  <= 1'b1;
          end
          if (!in_range) begin
            run_flag        <= 1'b0;
            sample_count    <= '0;
            segment_pointer <= '0;
            state           <= ST_LAST;
          end else if (sample_count < dur_q) begin
            if (trig) begin
              slope_idx <= '0;
              acc_after <= 1'b1;
              state     <= ST_SL_A;
            end else begin
              state <= ST_ACCUM;
            end
          end else begin
            segment_pointer <= seg_inc;
            sample_count    <= '0;
            if (seg_inc < total) begin
              slope_idx <= ADDR_W'(seg_inc);
              acc_after <= 1'b0;
              state     <= ST_SL_A;
            end else if (trig) begin
              slope_idx <= '0;
              acc_after <= 1'b0;
              state     <= ST_SL_A;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_LAST: begin
          level_acc <= level_to_acc(lvl_q);
          state     <= ST_FINISH;
        end
        ST_SL_A: state <= ST_SL_B;
        ST_SL_B: begin
          level_a <= lvl_q;
          div_d   <= dur_q;
          state   <= ST_SL_C;
        end
        ST_SL_C: begin
          div_neg <= diff[POINT_LEVEL_W];
          mag     <= diff_abs[POINT_LEVEL_W-1:0];
          state   <= ST_MUL;
        end
        ST_MUL: begin
          num_sr  <= {PROD_W'(mag) * PROD_W'(step_size), {FRACTION_BITS{1'b0}}};
          rem     <= '0;
          div_cnt <= CNT_W'(NUM_W);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          num_sr  <= {num_sr[NUM_W-2:0], 1'b0};
          quo     <= {quo[NUM_W-2:0], qbit};
          rem     <= qbit ? POINT_DUR_W'(trial - {1'b0, div_d}) : trial[POINT_DUR_W-1:0];
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) state <= ST_SL_DONE;
        end
        ST_SL_DONE: begin
          if (div_d == '0) begin
            slope <= '0;
          end else if (!div_neg) begin
            slope <= (q_hi != '0) ? ACC_MAX : q_mag;
          end else begin
            slope <= (q_hi > HI_W'(1) || (q_hi == HI_W'(1) && q_lo != '0)) ? ACC_MIN : -q_mag;
          end
          state <= acc_after ? ST_ACCUM : ST_FINISH;
        end
        ST_ACCUM: begin
          level_acc    <= sat_add(level_acc, slope);
          sample_count <= cnt_sum[POINT_DUR_W] ? '1 : cnt_sum[POINT_DUR_W-1:0];
          state        <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {{M_PAD_W{1'b0}}, segment_pointer, run_flag, level_out};
    end
  end

  `TBE_ASSERT_NEXT(a_accept_drops_ready, s_tvalid && s_tready, !s_tready)
  `TBE_ASSERT_NEXT(a_finish_emits, state == ST_FINISH && out_free, m_tvalid && state == ST_IDLE)
  `TBE_ASSERT_HOLDS(a_div_count_live, state == ST_DIV, div_cnt != '0)
  `TBE_ASSERT_HOLDS(a_rem_below_divisor, state == ST_DIV && div_d != '0, rem < div_d)

endmodule

`default_nettype wire

FILE: test/tb_triggered_breakpoint_envelope.sv
// Testbench for the triggered breakpoint envelope: streamed stimulus, predicted results, checks.
`timescale 1ns / 1ps

module tb_triggered_breakpoint_envelope;
  import tbe_pkg::*;

  localparam int SEGMENTS = 15;
  localparam int FRAC = 16;
  localparam longint ACC_MAX = 64'sd549755813887;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam int unsigned COUNT_MAX = 32'h00FFFFFF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic cmd;
    logic trig;
    logic [3:0] idx;
    logic signed [23:0] lvl;
    logic [23:0] dur;
  } env_item_t;

  typedef struct packed {
    logic [23:0] level;
    logic playing;
    logic [3:0] seg;
  } env_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  env_item_t items_to_send[$];
  env_result_t results_due[$];
  env_item_t item_on_bus;
  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int results_seen = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // envelope state as predicted
  longint acc;
  longint slope_r;
  bit running;
  int unsigned seg_ptr;
  int unsigned count;
  logic signed [23:0] lvl_tab [0:SEGMENTS];
  logic [23:0] dur_tab [0:SEGMENTS-1];
  int unsigned seg_total_r;
  int unsigned step_r;

  triggered_breakpoint_envelope u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sat_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic longint segment_slope(input int unsigned s);
    longint num;
    if (dur_tab[s[3:0]] == 24'd0) return 0;
    num = (longint'(lvl_tab[4'(s + 1)]) - longint'(lvl_tab[s[3:0]])) * longint'(step_r)
          * (64'sd1 <<< FRAC);
    return sat_acc(num / longint'({8'd0, dur_tab[s[3:0]]}));
  endfunction

  function automatic env_result_t advance_envelope(input env_item_t it);
    env_result_t res;
    int unsigned total;
    int unsigned c;
    longint whole;
    total = (seg_total_r > SEGMENTS) ? SEGMENTS : seg_total_r;
    if (it.cmd == CMD_LOAD) begin
      if (it.idx <= SEGMENTS) lvl_tab[it.idx] = it.lvl;
      if (it.idx < SEGMENTS) dur_tab[it.idx] = it.dur;
    end else begin
      if (it.trig) begin
        slope_r = segment_slope(0);
        acc = sat_acc(longint'(lvl_tab[0]) * (64'sd1 <<< FRAC));
        running = 1'b1;
      end
      if (running && seg_ptr < total) begin
        if (count < dur_tab[seg_ptr[3:0]]) begin
          c = count + step_r;
          acc = sat_acc(acc + slope_r);
          count = (c > COUNT_MAX) ? COUNT_MAX : c;
        end else begin
          seg_ptr++;
          count = 0;
          if (seg_ptr < total) slope_r = segment_slope(seg_ptr);
        end
      end else begin
        running = 1'b0;
        count = 0;
        seg_ptr = 0;
        acc = sat_acc(longint'(lvl_tab[total[3:0]]) * (64'sd1 <<< FRAC));
      end
    end
    whole = acc >>> FRAC;
    res.level = whole[23:0];
    res.playing = running;
    res.seg = seg_ptr[3:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("ERROR: result %0d %s: got %h, want %h", results_seen, what, got, want);
  endtask

  // driver: offer queued items, predict on acceptance
  always @(posedge clk) begin : drive_items
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) results_due = {results_due, advance_envelope(item_on_bus)};
      if (!s_tvalid || s_tready) begin
        if (items_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_on_bus = items_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, item_on_bus.dur, item_on_bus.lvl, item_on_bus.idx,
                      item_on_bus.trig};
          s_tuser <= item_on_bus.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    env_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 32'd0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[23:0] !== want.level)
          report_mismatch("level", 32'(m_tdata[23:0]), 32'(want.level));
        if (m_tdata[24] !== want.playing)
          report_mismatch("playing", 32'(m_tdata[24]), 32'(want.playing));
        if (m_tdata[28:25] !== want.seg)
          report_mismatch("segment_now", 32'(m_tdata[28:25]), 32'(want.seg));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("triggered_breakpoint_envelope regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SEGMENT_TOTAL) seg_total_r = val & 32'hF;
    else step_r = val & 32'h1FFF;
    #1;
  endtask

  task automatic wait_drained;
    while (items_to_send.size() != 0 || s_tvalid || results_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic push_load(input logic [3:0] idx, input logic [23:0] lvl, input logic [23:0] dur);
    env_item_t it;
    it.cmd = CMD_LOAD;
    it.trig = 1'($urandom_range(0, 1));
    it.idx = idx;
    it.lvl = lvl;
    it.dur = dur;
    items_to_send = {items_to_send, it};
  endtask

  task automatic push_tick(input logic trig);
    env_item_t it;
    logic [31:0] r;
    logic [31:0] r_lvl;
    logic [31:0] r_dur;
    r = $urandom;
    r_lvl = $urandom;
    r_dur = $urandom;
    it.cmd = CMD_TICK;
    it.trig = trig;
    it.idx = r[3:0];
    it.lvl = r_lvl[23:0];
    it.dur = r_dur[23:0];
    items_to_send = {items_to_send, it};
  endtask

  function automatic logic [23:0] rand_duration;
    int unsigned pick;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    r = $urandom;
    if (pick < 70) return 24'($urandom_range(0, 12));
    if (pick < 96) return 24'($urandom_range(0, 300));
    return r[23:0];
  endfunction

  function automatic logic [23:0] rand_level;
    int unsigned pick;
    logic [31:0] r;
    pick = $urandom_range(0, 9);
    r = $urandom;
    if (pick == 0) return 24'h800000;
    if (pick == 1) return 24'h7FFFFF;
    return r[23:0];
  endfunction

  initial begin : stimulus
    int unsigned pick;
    int unsigned seg_cfg;
    int unsigned step_cfg;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    send_idle_pct = 15;
    recv_idle_pct = 77;
    acc = 0;
    slope_r = 0;
    running = 1'b0;
    seg_ptr = 0;
    count = 0;
    seg_total_r = 1;
    step_r = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: full table, extremes, zero duration, retrigger
    write_reg(REG_SEGMENT_TOTAL, 3);
    write_reg(REG_STEP_SIZE, 1);
    push_load(4'd0, 24'h800000, 24'd0);
    push_load(4'd1, 24'h7FFFFF, 24'd3);
    push_load(4'd2, 24'd0, 24'd2);
    push_load(4'd3, 24'h800000, 24'd5);
    for (int i = 4; i < SEGMENTS - 1; i++) push_load(i[3:0], rand_level(), rand_duration());
    push_load(4'd14, 24'h123456, 24'hFFFFFF);
    push_load(4'd15, 24'h7FFFFF, 24'hFFFFFF);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drained();

    // no segments: stay at the first breakpoint; step 4096
    write_reg(REG_SEGMENT_TOTAL, 0);
    write_reg(REG_STEP_SIZE, 4096);
    push_tick(1'b0);
    push_tick(1'b1);
    push_load(4'd0, 24'h7FFFFF, 24'd1);
    push_tick(1'b0);
    wait_drained();

    // zero step: count holds
    write_reg(REG_SEGMENT_TOTAL, SEGMENTS);
    write_reg(REG_STEP_SIZE, 0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 77;
      end else if (p < 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) begin
        seg_cfg = SEGMENTS;
        step_cfg = 1;
      end else if (p == 1) begin
        seg_cfg = 1;
        step_cfg = 4096;
      end else begin
        seg_cfg = $urandom_range(1, SEGMENTS);
        pick = $urandom_range(0, 99);
        if (pick < 50) step_cfg = $urandom_range(1, 4);
        else if (pick < 80) step_cfg = $urandom_range(5, 64);
        else step_cfg = $urandom_range(65, 4096);
      end
      write_reg(REG_SEGMENT_TOTAL, seg_cfg);
      write_reg(REG_STEP_SIZE, step_cfg);
      push_tick(1'b1);
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) push_load(4'($urandom_range(0, SEGMENTS)), rand_level(), rand_duration());
        else push_tick(pick < 16);
      end
      wait_drained();
    end

    repeat (70) @(posedge clk);
    #1;
    if (errors == 0) begin
      $display("triggered_breakpoint_envelope regression: pass");
    end else begin
      $display("triggered_breakpoint_envelope regression: fail");
    end
    $finish;
  end

endmodule
